// ----- sv/gbr_pkg.sv -----
// ----------------------------------------------------------------------------
// gbr_pkg
// Shared widths, register indexes, reset values and the token type of the
// 3x3 rgb blur.
// ----------------------------------------------------------------------------
`default_nettype none

package gbr_pkg;

  localparam int PIX_W     = 8;
  localparam int RGB_W     = 3 * PIX_W;
  localparam int COEF_W    = 16;
  localparam int FRAC_W    = 16;
  localparam int IMG_W_W   = 12;
  localparam int IMG_H_W   = 13;
  localparam int NUM_BUF   = 4;
  localparam int BUF_W     = 2;
  localparam int TAPS      = 3;
  localparam int LANES     = 3;
  localparam int SUM4_W    = PIX_W + 2;
  localparam int ACC_W     = SUM4_W + COEF_W + 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_EDGE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CORNER  = 3'd4;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 12'd1920;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 13'd1080;
  localparam logic [COEF_W-1:0]  COEF_CENTER_RST  = 16'd21287;
  localparam logic [COEF_W-1:0]  COEF_EDGE_RST    = 16'd7672;
  localparam logic [COEF_W-1:0]  COEF_CORNER_RST  = 16'd2765;

  // per output pixel: frame end flag and line buffer of each window row
  typedef struct packed {
    logic                         last;
    logic [TAPS-1:0][BUF_W-1:0]   row_sel;
  } tok_t;

endpackage

`default_nettype wire

// ----- sv/gbr_ram.sv -----
// ----------------------------------------------------------------------------
// gbr_ram
// Generic single write port, single read port ram with registered read data
// (read returns the old word on a same-address write).
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- sv/gbr_ctrl.sv -----
// ----------------------------------------------------------------------------
// gbr_ctrl
// Input and output position counters, output readiness, line buffer write
// and window address generation (first pipeline stage).
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_ctrl #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic [gbr_pkg::IMG_W_W-1:0]              image_width,
  input  wire logic [gbr_pkg::IMG_H_W-1:0]              image_height,
  input  wire logic                                     in_valid,
  input  wire logic                                     stage_en,
  input  wire logic [gbr_pkg::PIX_W-1:0]                in_pixel_red,
  input  wire logic [gbr_pkg::PIX_W-1:0]                in_pixel_green,
  input  wire logic [gbr_pkg::PIX_W-1:0]                in_pixel_blue,
  input  wire logic                                     in_is_flush,
  output logic                                          wr_en,
  output logic      [gbr_pkg::BUF_W-1:0]                wr_buf,
  output logic      [$clog2(MAX_WIDTH)-1:0]             wr_col,
  output logic      [gbr_pkg::RGB_W-1:0]                wr_data,
  output logic                                          s1_valid,
  output logic      [gbr_pkg::TAPS-1:0][$clog2(MAX_WIDTH)-1:0] s1_col,
  output gbr_pkg::tok_t                                 s1_tok
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CXW = CW + 1;
  localparam int WXW = (CXW > gbr_pkg::IMG_W_W) ? CXW : gbr_pkg::IMG_W_W;
  localparam int HW  = gbr_pkg::IMG_H_W;
  localparam int HXW = HW + 1;

  logic [CW-1:0]  col_cnt_r, col_cnt_nxt;
  logic [HW-1:0]  row_cnt_r, row_cnt_nxt;
  logic [CW-1:0]  out_col_r, out_col_nxt;
  logic [HW-1:0]  out_row_r, out_row_nxt;

  logic                                  s1_valid_r;
  logic [gbr_pkg::TAPS-1:0][CW-1:0]      s1_col_r;
  gbr_pkg::tok_t                         s1_tok_r;

  logic [WXW-1:0] w_ext;
  logic [CXW-1:0] eff_w;
  logic [HW-1:0]  eff_h;
  logic           accept;
  logic           take_pix;
  logic [CXW-1:0] col_inc;
  logic [CW-1:0]  col_a;
  logic [HW-1:0]  row_a;
  logic [HW-1:0]  cr, nr, r_up;
  logic [HXW-1:0] cr_inc;
  logic [CW-1:0]  cc, nc, c_l;
  logic [CXW-1:0] cc_inc;
  logic           out_rdy;
  logic           emit;
  logic [CXW-1:0] oc_inc;
  logic [CW-1:0]  oc_n;
  logic [HXW-1:0] or_n;
  logic           last;

  always_comb begin
    w_ext = WXW'(image_width);
    if (image_width == '0) begin
      eff_w = CXW'(1);
    end else if (w_ext > WXW'(MAX_WIDTH)) begin
      eff_w = CXW'(MAX_WIDTH);
    end else begin
      eff_w = CXW'(w_ext);
    end
    eff_h = (image_height == '0) ? HW'(1) : image_height;
  end

  assign accept   = in_valid && stage_en;
  // pixels past the end of the frame are dropped
  assign take_pix = accept && !in_is_flush && (row_cnt_r < eff_h);

  always_comb begin
    col_inc = CXW'(col_cnt_r) + CXW'(1);
    col_a   = col_cnt_r;
    row_a   = row_cnt_r;
    if (take_pix) begin
      if (col_inc >= eff_w) begin
        col_a = '0;
        row_a = row_cnt_r + HW'(1);
      end else begin
        col_a = col_inc[CW-1:0];
      end
    end
  end

  // window position, clamped to the image
  always_comb begin
    cr     = (out_row_r < eff_h) ? out_row_r : eff_h - HW'(1);
    cc     = (CXW'(out_col_r) < eff_w) ? out_col_r : CW'(eff_w - CXW'(1));
    cr_inc = HXW'(cr) + HXW'(1);
    nr     = (cr_inc < HXW'(eff_h)) ? cr_inc[HW-1:0] : eff_h - HW'(1);
    cc_inc = CXW'(cc) + CXW'(1);
    nc     = (cc_inc < eff_w) ? cc_inc[CW-1:0] : CW'(eff_w - CXW'(1));
    r_up   = (cr == '0) ? '0 : cr - HW'(1);
    c_l    = (cc == '0) ? '0 : cc - CW'(1);
  end

  assign out_rdy = (row_a > nr) || ((row_a == nr) && (col_a > nc));
  assign emit    = accept && out_rdy;

  always_comb begin
    oc_inc = CXW'(out_col_r) + CXW'(1);
    if (oc_inc >= eff_w) begin
      oc_n = '0;
      or_n = HXW'(out_row_r) + HXW'(1);
    end else begin
      oc_n = oc_inc[CW-1:0];
      or_n = HXW'(out_row_r);
    end
    last = (or_n >= HXW'(eff_h));
  end

  always_comb begin
    col_cnt_nxt = col_a;
    row_cnt_nxt = row_a;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (emit) begin
      out_col_nxt = oc_n;
      out_row_nxt = or_n[HW-1:0];
      // frame done: start over
      if (last) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      if (stage_en) begin
        s1_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en && emit) begin
      s1_col_r[0]         <= c_l;
      s1_col_r[1]         <= cc;
      s1_col_r[2]         <= nc;
      s1_tok_r.last       <= last;
      s1_tok_r.row_sel[0] <= r_up[gbr_pkg::BUF_W-1:0];
      s1_tok_r.row_sel[1] <= cr[gbr_pkg::BUF_W-1:0];
      s1_tok_r.row_sel[2] <= nr[gbr_pkg::BUF_W-1:0];
    end
  end

  assign wr_en    = take_pix;
  assign wr_buf   = row_cnt_r[gbr_pkg::BUF_W-1:0];
  assign wr_col   = col_cnt_r;
  assign wr_data  = {in_pixel_red, in_pixel_green, in_pixel_blue};
  assign s1_valid = s1_valid_r;
  assign s1_col   = s1_col_r;
  assign s1_tok   = s1_tok_r;

endmodule

`default_nettype wire

// ----- sv/gbr_lane.sv -----
// ----------------------------------------------------------------------------
// gbr_lane
// One color channel of the blur: neighbor sums, coefficient products, then
// Q0.16 truncation and saturation to 8 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module gbr_lane (
  input  wire logic                                     clk,
  input  wire logic                                     en_sum,
  input  wire logic                                     en_mul,
  input  wire logic [gbr_pkg::COEF_W-1:0]               coef_center,
  input  wire logic [gbr_pkg::COEF_W-1:0]               coef_edge,
  input  wire logic [gbr_pkg::COEF_W-1:0]               coef_corner,
  input  wire logic [gbr_pkg::PIX_W-1:0]                pix_c,
  input  wire logic [3:0][gbr_pkg::PIX_W-1:0]           pix_e,
  input  wire logic [3:0][gbr_pkg::PIX_W-1:0]           pix_k,
  output logic      [gbr_pkg::PIX_W-1:0]                res
);

  localparam int SW  = gbr_pkg::SUM4_W;
  localparam int PCW = gbr_pkg::PIX_W + gbr_pkg::COEF_W;
  localparam int PSW = SW + gbr_pkg::COEF_W;
  localparam int AW  = gbr_pkg::ACC_W;
  localparam int QW  = AW - gbr_pkg::FRAC_W;

  logic [gbr_pkg::PIX_W-1:0] c_r;
  logic [SW-1:0]             e_r;
  logic [SW-1:0]             k_r;
  logic [PCW-1:0]            pc_r;
  logic [PSW-1:0]            pe_r;
  logic [PSW-1:0]            pk_r;
  logic [AW-1:0]             acc;
  logic [QW-1:0]             scaled;

  always_ff @(posedge clk) begin
    if (en_sum) begin
      c_r <= pix_c;
      e_r <= SW'(pix_e[0]) + SW'(pix_e[1]) + SW'(pix_e[2]) + SW'(pix_e[3]);
      k_r <= SW'(pix_k[0]) + SW'(pix_k[1]) + SW'(pix_k[2]) + SW'(pix_k[3]);
    end
    if (en_mul) begin
      pc_r <= PCW'(c_r) * PCW'(coef_center);
      pe_r <= PSW'(e_r) * PSW'(coef_edge);
      pk_r <= PSW'(k_r) * PSW'(coef_corner);
    end
  end

  always_comb begin
    acc    = AW'(pc_r) + AW'(pe_r) + AW'(pk_r);
    scaled = acc[AW-1:gbr_pkg::FRAC_W];
    if (|scaled[QW-1:gbr_pkg::PIX_W]) begin
      res = '1;
    end else begin
      res = scaled[gbr_pkg::PIX_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- sv/gaussian_blur_3x3_rgb.sv -----
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_rgb
// 3x3 gaussian blur of an rgb raster stream with edge replication.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in_ channel (valid/ready); a transaction
// with in_is_flush set carries no pixel and only drains one pending result.
// Each blurred pixel leaves on the out_ channel; out_end_of_frame marks the
// last one of a frame, after which the position counters restart.
// A result is produced by the transaction that completes its 3x3 neighborhood,
// about one row plus one pixel after the pixel itself; the last row is
// drained by flush transactions. The result then passes the address stage,
// line buffer read, sums, products and output register to out_valid.
// Throughput is one transaction per clock when out_ready does not stall, set
// by the single write and per-tap read ports of the four line buffers.
// When out_ready is low the output register holds; in_ready stays high while
// any of the four inner stages is empty, then drops until the output drains.
// Reset (rst_n low, synchronous) empties the pipeline, clears the counters and
// loads the default size and coefficients; line buffers are not cleared and
// hold nothing meaningful until written. Configuration writes take effect at
// once; the user must make them only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_3x3_rgb #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [gbr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gbr_pkg::COEF_W-1:0]      cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [gbr_pkg::PIX_W-1:0]       in_pixel_red,
  input  wire logic [gbr_pkg::PIX_W-1:0]       in_pixel_green,
  input  wire logic [gbr_pkg::PIX_W-1:0]       in_pixel_blue,
  input  wire logic                            in_is_flush,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [gbr_pkg::PIX_W-1:0]       out_red,
  output logic      [gbr_pkg::PIX_W-1:0]       out_green,
  output logic      [gbr_pkg::PIX_W-1:0]       out_blue,
  output logic                                 out_end_of_frame
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PW = gbr_pkg::PIX_W;

  logic [gbr_pkg::IMG_W_W-1:0] image_width_r;
  logic [gbr_pkg::IMG_H_W-1:0] image_height_r;
  logic [gbr_pkg::COEF_W-1:0]  coef_center_r;
  logic [gbr_pkg::COEF_W-1:0]  coef_edge_r;
  logic [gbr_pkg::COEF_W-1:0]  coef_corner_r;

  logic                                    wr_en;
  logic [gbr_pkg::BUF_W-1:0]               wr_buf;
  logic [CW-1:0]                           wr_col;
  logic [gbr_pkg::RGB_W-1:0]               wr_data;
  logic                                    s1_valid;
  logic [gbr_pkg::TAPS-1:0][CW-1:0]        s1_col;
  gbr_pkg::tok_t                           s1_tok;

  logic en1, en2, en3, en4, en_out;
  logic v2_r, v3_r, v4_r, out_valid_r;
  gbr_pkg::tok_t tok2_r;
  logic last3_r, last4_r;

  logic [gbr_pkg::RGB_W-1:0] ram_q [gbr_pkg::NUM_BUF][gbr_pkg::TAPS];
  logic [gbr_pkg::RGB_W-1:0] win   [gbr_pkg::TAPS][gbr_pkg::TAPS];
  logic [gbr_pkg::LANES-1:0][PW-1:0] lane_res;

  logic [PW-1:0] out_red_r, out_green_r, out_blue_r;
  logic          out_eof_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= gbr_pkg::IMAGE_WIDTH_RST;
      image_height_r <= gbr_pkg::IMAGE_HEIGHT_RST;
      coef_center_r  <= gbr_pkg::COEF_CENTER_RST;
      coef_edge_r    <= gbr_pkg::COEF_EDGE_RST;
      coef_corner_r  <= gbr_pkg::COEF_CORNER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gbr_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[gbr_pkg::IMG_W_W-1:0];
        gbr_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_data[gbr_pkg::IMG_H_W-1:0];
        gbr_pkg::REG_COEF_CENTER:  coef_center_r  <= cfg_data;
        gbr_pkg::REG_COEF_EDGE:    coef_edge_r    <= cfg_data;
        gbr_pkg::REG_COEF_CORNER:  coef_corner_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when it is empty or its successor moves
  assign en_out   = !out_valid_r || out_ready;
  assign en4      = !v4_r || en_out;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  gbr_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .image_width    (image_width_r),
    .image_height   (image_height_r),
    .in_valid       (in_valid),
    .stage_en       (en1),
    .in_pixel_red   (in_pixel_red),
    .in_pixel_green (in_pixel_green),
    .in_pixel_blue  (in_pixel_blue),
    .in_is_flush    (in_is_flush),
    .wr_en          (wr_en),
    .wr_buf         (wr_buf),
    .wr_col         (wr_col),
    .wr_data        (wr_data),
    .s1_valid       (s1_valid),
    .s1_col         (s1_col),
    .s1_tok         (s1_tok)
  );

  // four row buffers, one copy per window column so all taps read at once
  for (genvar b = 0; b < gbr_pkg::NUM_BUF; b++) begin : g_buf
    for (genvar j = 0; j < gbr_pkg::TAPS; j++) begin : g_tap
      gbr_ram #(
        .WIDTH (gbr_pkg::RGB_W),
        .DEPTH (MAX_WIDTH)
      ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en && (wr_buf == gbr_pkg::BUF_W'(b))),
        .wr_addr (wr_col),
        .wr_data (wr_data),
        .rd_en   (en2),
        .rd_addr (s1_col[j]),
        .rd_data (ram_q[b][j])
      );
    end
  end

  always_comb begin
    for (int i = 0; i < gbr_pkg::TAPS; i++) begin
      for (int j = 0; j < gbr_pkg::TAPS; j++) begin
        win[i][j] = ram_q[tok2_r.row_sel[i]][j];
      end
    end
  end

  // lane 0 is red (top byte), lane 2 is blue
  for (genvar l = 0; l < gbr_pkg::LANES; l++) begin : g_lane
    localparam int SH = (gbr_pkg::LANES - 1 - l) * PW;
    logic [PW-1:0]         pix_c;
    logic [3:0][PW-1:0]    pix_e;
    logic [3:0][PW-1:0]    pix_k;

    assign pix_c    = win[1][1][SH +: PW];
    assign pix_e[0] = win[0][1][SH +: PW];
    assign pix_e[1] = win[2][1][SH +: PW];
    assign pix_e[2] = win[1][0][SH +: PW];
    assign pix_e[3] = win[1][2][SH +: PW];
    assign pix_k[0] = win[0][0][SH +: PW];
    assign pix_k[1] = win[0][2][SH +: PW];
    assign pix_k[2] = win[2][0][SH +: PW];
    assign pix_k[3] = win[2][2][SH +: PW];

    gbr_lane u_lane (
      .clk         (clk),
      .en_sum      (en3),
      .en_mul      (en4),
      .coef_center (coef_center_r),
      .coef_edge   (coef_edge_r),
      .coef_corner (coef_corner_r),
      .pix_c       (pix_c),
      .pix_e       (pix_e),
      .pix_k       (pix_k),
      .res         (lane_res[l])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en2) begin
        v2_r <= s1_valid;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
      if (en_out) begin
        out_valid_r <= v4_r;
      end
    end
  end

  // merge the three lanes into the output register
  always_ff @(posedge clk) begin
    if (en2) begin
      tok2_r <= s1_tok;
    end
    if (en3) begin
      last3_r <= tok2_r.last;
    end
    if (en4) begin
      last4_r <= last3_r;
    end
    if (en_out) begin
      out_red_r   <= lane_res[0];
      out_green_r <= lane_res[1];
      out_blue_r  <= lane_res[2];
      out_eof_r   <= last4_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red          = out_red_r;
  assign out_green        = out_green_r;
  assign out_blue         = out_blue_r;
  assign out_end_of_frame = out_eof_r;

endmodule

`default_nettype wire
